@@ src/pfgr_pkg.sv @@
package pfgr_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam logic [3:0] RAW_DYN_F   = 4'd14;
   localparam logic [3:0] REPEAT_CODE = 4'd14;
   localparam logic [3:0] REPEAT_ONCE = 4'd15;
   localparam logic [6:0] REPEAT_MAX  = 7'd127;

   localparam logic [1:0] REG_DYN_F        = 2'd0;
   localparam logic [1:0] REG_START_BLACK  = 2'd1;
   localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd2;
   localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd3;

   typedef struct packed {
      logic [3:0] dyn_f;
      logic       start_black;
      logic [6:0] glyph_width;
      logic [6:0] glyph_height;
   } cfg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NYB,
      S_PAINT,
      S_RAW,
      S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_NYB,
      OP_PAINT,
      OP_PAINT_END,
      OP_RAW,
      OP_EMIT,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_ZEROS,
      PH_LONG,
      PH_SECOND
   } phase_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_raw;
      logic glyph_done;
      logic nyb_paint;
      logic nyb_lo;
      logic run_end;
      logic paint_full;
      logic raw_full;
      logic bits_empty;
      logic emit_end;
      logic out_free;
   } stat_type;

   // 0 acts as 1, anything above the maximum acts as the maximum
   function automatic logic [6:0] eff_dim(input logic [6:0] v, input logic [6:0] vmax);
      logic [6:0] r;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (v > vmax) begin
         r = vmax;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ src/pfgr_ctrl.sv @@
module pfgr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pfgr_pkg::stat_type stat,
   output pfgr_pkg::cmd_type  cmd
);
   import pfgr_pkg::*;

   state_type state_ff, state_in;
   logic      ret_raw_ff, ret_raw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_raw_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_raw_ff <= ret_raw_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ret_raw_in = ret_raw_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_ACCEPT;
               state_in = stat.is_raw ? S_RAW : S_NYB;
            end
         end
         S_NYB: begin
            if (stat.glyph_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_NYB;
               if (stat.nyb_paint) begin
                  state_in = S_PAINT;
               end else if (stat.nyb_lo) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAINT: begin
            if (stat.run_end || stat.glyph_done) begin
               cmd.op   = OP_PAINT_END;
               state_in = (!stat.nyb_lo && !stat.glyph_done) ? S_NYB : S_IDLE;
            end else begin
               cmd.op = OP_PAINT;
               if (stat.paint_full) begin
                  state_in   = S_EMIT;
                  ret_raw_in = 1'b0;
               end
            end
         end
         S_RAW: begin
            if (stat.glyph_done || stat.bits_empty) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_RAW;
               if (stat.raw_full) begin
                  state_in   = S_EMIT;
                  ret_raw_in = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (stat.glyph_done || stat.emit_end) begin
               cmd.op   = OP_FINISH;
               state_in = ret_raw_ff ? S_RAW : S_PAINT;
            end else if (stat.out_free) begin
               cmd.op = OP_EMIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/pfgr_dp.sv @@
module pfgr_dp (
   input  logic               clock,
   input  logic               reset,
   input  pfgr_pkg::cmd_type  cmd,
   input  pfgr_pkg::cfg_type  cfg,
   input  logic               glyph_start,
   input  logic [7:0]         raster_byte,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [63:0]        row_bits,
   output logic [5:0]         row_number,
   output logic               last_row,
   output pfgr_pkg::stat_type stat
);
   import pfgr_pkg::*;

   localparam logic [63:0] ONES = '1;

   phase_type   phase_ff, phase_in;
   logic [3:0]  lz_ff, lz_in;
   logic [31:0] acc_ff, acc_in;
   logic        dr_ff, dr_in;
   logic        pb_ff, pb_in;
   logic [63:0] row_ff, row_in;
   logic [6:0]  pl_ff, pl_in;
   logic [6:0]  rows_ff, rows_in;
   logic [6:0]  rep_ff, rep_in;
   logic        done_ff, done_in;
   logic        nyb_lo_ff, nyb_lo_in;
   logic [31:0] run_ff, run_in;
   logic [7:0]  sr_ff, sr_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  emit_ff, emit_in;
   logic        valid_ff, valid_in;
   logic [63:0] obits_ff, obits_in;
   logic [5:0]  onum_ff, onum_in;
   logic        olast_ff, olast_in;

   // decoder outcome for the current nybble
   phase_type   dec_phase;
   logic [3:0]  dec_lz;
   logic [31:0] dec_acc;
   logic        dec_dr;
   logic [6:0]  dec_rep;

   logic [6:0]  w, h, c, k, pl_t, rows_t;
   logic [3:0]  n, d, lz_dec, kr;
   logic        deliver;
   logic [31:0] v, acc_long;
   logic [34:0] s_long;
   logic signed [11:0] s_sec;
   logic [63:0] pmask, rchunk;
   logic [7:0]  rtop;
   logic        out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         lz_ff     <= '0;
         acc_ff    <= '0;
         dr_ff     <= 1'b0;
         pb_ff     <= 1'b0;
         row_ff    <= '0;
         pl_ff     <= 7'(MAX_WIDTH);
         rows_ff   <= '0;
         rep_ff    <= '0;
         done_ff   <= 1'b0;
         nyb_lo_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         lz_ff     <= lz_in;
         acc_ff    <= acc_in;
         dr_ff     <= dr_in;
         pb_ff     <= pb_in;
         row_ff    <= row_in;
         pl_ff     <= pl_in;
         rows_ff   <= rows_in;
         rep_ff    <= rep_in;
         done_ff   <= done_in;
         nyb_lo_ff <= nyb_lo_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff   <= run_in;
      sr_ff    <= sr_in;
      bits_ff  <= bits_in;
      emit_ff  <= emit_in;
      obits_ff <= obits_in;
      onum_ff  <= onum_in;
      olast_ff <= olast_in;
   end

   // packed-number decoder for the current nybble
   always_comb begin
      w = eff_dim(cfg.glyph_width, 7'(MAX_WIDTH));
      h = eff_dim(cfg.glyph_height, 7'(MAX_HEIGHT));
      d = cfg.dyn_f;
      n = nyb_lo_ff ? sr_ff[3:0] : sr_ff[7:4];
      lz_dec   = (lz_ff != 4'd0) ? lz_ff - 4'd1 : 4'd0;
      acc_long = (acc_ff > 32'h0FFF_FFFF) ? '1 : {acc_ff[27:0], n};
      s_long   = {3'b0, acc_long} + 35'd193 - 35'({d, 4'b0} - {4'b0, d});
      s_sec    = ((12'(acc_ff[3:0]) - 12'(d) - 12'sd1) <<< 4) + 12'(n) + 12'(d) + 12'sd1;
      dec_phase = phase_ff;
      dec_lz    = lz_ff;
      dec_acc   = acc_ff;
      dec_dr    = dr_ff;
      dec_rep   = rep_ff;
      deliver   = 1'b0;
      v         = '0;
      case (phase_ff)
         PH_ZEROS: begin
            if (n == 4'd0) begin
               if (lz_ff != 4'hF) dec_lz = lz_ff + 4'd1;
            end else begin
               dec_acc   = 32'(n);
               dec_phase = PH_LONG;
            end
         end
         PH_LONG: begin
            dec_acc = acc_long;
            dec_lz  = lz_dec;
            if (lz_dec == 4'd0) begin
               dec_phase = PH_FIRST;
               deliver   = 1'b1;
               if (s_long[34]) begin
                  v = '0;
               end else if (s_long[33:32] != 2'b0) begin
                  v = '1;
               end else begin
                  v = s_long[31:0];
               end
            end
         end
         PH_SECOND: begin
            dec_phase = PH_FIRST;
            deliver   = 1'b1;
            v         = s_sec[11] ? 32'd0 : 32'(s_sec[10:0]);
         end
         default: begin
            dec_phase = PH_FIRST;
            if (n == 4'd0) begin
               dec_lz    = 4'd1;
               dec_phase = PH_ZEROS;
            end else if (n <= d) begin
               deliver = 1'b1;
               v       = 32'(n);
            end else if (n < REPEAT_CODE) begin
               dec_acc   = 32'(n);
               dec_phase = PH_SECOND;
            end else if (!dr_ff) begin
               if (n == REPEAT_CODE) dec_dr = 1'b1;
               else if (n == REPEAT_ONCE) dec_rep = 7'd1;
            end
         end
      endcase
      if (deliver && dr_ff) begin
         dec_rep = (v > 32'(REPEAT_MAX)) ? REPEAT_MAX : v[6:0];
         dec_dr  = 1'b0;
      end
   end

   // run painting and raw bit placement
   always_comb begin
      c      = w - pl_ff;
      k      = (run_ff < 32'(pl_ff)) ? run_ff[6:0] : pl_ff;
      pmask  = (ONES >> c) & ~(ONES >> (c + k));
      kr     = (7'(bits_ff) < pl_ff) ? bits_ff : pl_ff[3:0];
      rtop   = sr_ff & ~(8'hFF >> kr);
      rchunk = {rtop, 56'b0} >> c;
      out_free = !valid_ff || rsp_tready;
      pl_t   = glyph_start ? w : pl_ff;
      rows_t = glyph_start ? 7'd0 : rows_ff;
   end

   always_comb begin
      pb_in     = pb_ff;
      row_in    = row_ff;
      pl_in     = pl_ff;
      rows_in   = rows_ff;
      done_in   = done_ff;
      nyb_lo_in = nyb_lo_ff;
      run_in    = run_ff;
      sr_in     = sr_ff;
      bits_in   = bits_ff;
      emit_in   = emit_ff;
      valid_in  = valid_ff && !rsp_tready;
      obits_in  = obits_ff;
      onum_in   = onum_ff;
      olast_in  = olast_ff;
      unique case (cmd.op)
         OP_ACCEPT: begin
            if (glyph_start) begin
               phase_in = PH_FIRST;
               lz_in    = '0;
               acc_in   = '0;
               dr_in    = 1'b0;
               rep_in   = '0;
               pb_in    = cfg.start_black;
               row_in   = '0;
               rows_in  = '0;
            end else begin
               phase_in = phase_ff;
               lz_in    = lz_ff;
               acc_in   = acc_ff;
               dr_in    = dr_ff;
               rep_in   = rep_ff;
            end
            pl_in     = (pl_t == 7'd0 || pl_t > w) ? w : pl_t;
            done_in   = (glyph_start ? 1'b0 : done_ff) | (rows_t >= h);
            sr_in     = raster_byte;
            bits_in   = 4'd8;
            nyb_lo_in = 1'b0;
         end
         OP_NYB: begin
            phase_in = dec_phase;
            lz_in    = dec_lz;
            acc_in   = dec_acc;
            dr_in    = dec_dr;
            rep_in   = dec_rep;
            if (deliver && !dr_ff) begin
               run_in = v;
            end else begin
               nyb_lo_in = 1'b1;
            end
         end
         OP_PAINT: begin
            phase_in = phase_ff;
            lz_in    = lz_ff;
            acc_in   = acc_ff;
            dr_in    = dr_ff;
            rep_in   = rep_ff;
            if (pb_ff) row_in = row_ff | pmask;
            pl_in   = pl_ff - k;
            run_in  = run_ff - 32'(k);
            emit_in = 8'(rep_ff) + 8'd1;
         end
         OP_PAINT_END: begin
            phase_in  = phase_ff;
            lz_in     = lz_ff;
            acc_in    = acc_ff;
            dr_in     = dr_ff;
            rep_in    = rep_ff;
            pb_in     = !pb_ff;
            nyb_lo_in = 1'b1;
         end
         OP_RAW: begin
            phase_in = phase_ff;
            lz_in    = lz_ff;
            acc_in   = acc_ff;
            dr_in    = dr_ff;
            rep_in   = rep_ff;
            row_in   = row_ff | rchunk;
            pl_in    = pl_ff - 7'(kr);
            sr_in    = sr_ff << kr;
            bits_in  = bits_ff - kr;
            emit_in  = 8'(rep_ff) + 8'd1;
         end
         OP_EMIT: begin
            phase_in = phase_ff;
            lz_in    = lz_ff;
            acc_in   = acc_ff;
            dr_in    = dr_ff;
            rep_in   = rep_ff;
            valid_in = 1'b1;
            obits_in = row_ff;
            onum_in  = rows_ff[5:0];
            olast_in = (rows_ff + 7'd1 == h);
            rows_in  = rows_ff + 7'd1;
            if (rows_ff + 7'd1 >= h) done_in = 1'b1;
            emit_in  = emit_ff - 8'd1;
         end
         OP_FINISH: begin
            phase_in = phase_ff;
            lz_in    = lz_ff;
            acc_in   = acc_ff;
            dr_in    = dr_ff;
            rep_in   = '0;
            row_in   = '0;
            pl_in    = w;
         end
         default: begin
            phase_in = phase_ff;
            lz_in    = lz_ff;
            acc_in   = acc_ff;
            dr_in    = dr_ff;
            rep_in   = rep_ff;
         end
      endcase
   end

   assign stat.is_raw     = (cfg.dyn_f >= RAW_DYN_F);
   assign stat.glyph_done = done_ff;
   assign stat.nyb_paint  = deliver && !dr_ff;
   assign stat.nyb_lo     = nyb_lo_ff;
   assign stat.run_end    = (run_ff == 32'd0);
   assign stat.paint_full = (pl_ff == k);
   assign stat.raw_full   = (pl_ff == 7'(kr));
   assign stat.bits_empty = (bits_ff == 4'd0);
   assign stat.emit_end   = (emit_ff == 8'd0);
   assign stat.out_free   = out_free;

   assign rsp_tvalid = valid_ff;
   assign row_bits   = obits_ff;
   assign row_number = onum_ff;
   assign last_row   = olast_ff;

endmodule

@@ src/packed_font_glyph_raster_decoder_unit.sv @@
// Packed glyph raster decoder. Raster bytes of one glyph come in on the req
// stream (tuser set on the first byte of a new glyph); finished rows leave on
// the rsp stream, one word per row, with tlast on the glyph's final row. With
// dyn_f 0..13 each byte carries two run-length nybbles (high first), decoded
// in short, two-nybble and long form, with repeat-row codes; dyn_f 14 or 15
// reads the bytes as a plain bitmap, MSB first. For each accepted byte the
// sequencer takes the byte, then in packed mode decodes its nybbles in turn;
// a nybble that ends a run count paints the run row segment by row segment
// and then closes it (a zero run is only closed). Every completed row is
// sent once per copy, waiting while the output is stalled, and is then
// cleared. In bitmap mode the byte is placed as one row segment, or more
// when it crosses a row boundary, with the same row handling. The sequencer
// handles one byte at a time, so a long run or a row repeat holds off
// req_tready until every row it causes has been handed to the output
// register. Rows past the glyph height are dropped until the next glyph
// starts.
module packed_font_glyph_raster_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // req stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raster_byte
   input  logic        req_tuser,   // [0] glyph_start
   // rsp stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] row_bits, [69:64] row_number, rest zero
   output logic        rsp_tlast,   // last_row
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pfgr_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   cmd_type     cmd;
   stat_type    stat;
   logic        wr_en;
   logic [63:0] row_bits;
   logic [5:0]  row_number;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dyn_f        <= RAW_DYN_F;
         cfg_ff.start_black  <= 1'b0;
         cfg_ff.glyph_width  <= 7'(MAX_WIDTH);
         cfg_ff.glyph_height <= 7'(MAX_HEIGHT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_DYN_F:        cfg_in.dyn_f        = csr_pwdata[3:0];
            REG_START_BLACK:  cfg_in.start_black  = csr_pwdata[0];
            REG_GLYPH_WIDTH:  cfg_in.glyph_width  = csr_pwdata[6:0];
            REG_GLYPH_HEIGHT: cfg_in.glyph_height = csr_pwdata[6:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DYN_F:        csr_prdata = {28'b0, cfg_ff.dyn_f};
         REG_START_BLACK:  csr_prdata = {31'b0, cfg_ff.start_black};
         REG_GLYPH_WIDTH:  csr_prdata = {25'b0, cfg_ff.glyph_width};
         REG_GLYPH_HEIGHT: csr_prdata = {25'b0, cfg_ff.glyph_height};
         default:          csr_prdata = '0;
      endcase
   end

   pfgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pfgr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg_ff),
      .glyph_start (req_tuser),
      .raster_byte (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .row_bits    (row_bits),
      .row_number  (row_number),
      .last_row    (rsp_tlast),
      .stat        (stat)
   );

   assign rsp_tdata = {2'b0, row_number, row_bits};

   // a row word held back by the receiver stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("row word changed while stalled");

   // pixels right of the glyph width stay white
   a_row_within_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[63:0] & (64'hFFFF_FFFF_FFFF_FFFF >>
            eff_dim(cfg_ff.glyph_width, 7'(MAX_WIDTH)))) == 64'd0)
      else $error("black pixel beyond glyph width");

endmodule

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfgr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] raster_byte
   logic        req_tuser = 1'b0;  // [0] glyph_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [63:0] row_bits, [69:64] row_number, rest zero
   logic        rsp_tlast;         // last_row
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   packed_font_glyph_raster_decoder_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one expected output row
   typedef struct {
      logic [63:0] bits;
      logic [5:0]  num;
      logic        last;
   } row_type;

   // shadow registers and decoder state
   logic [3:0]  m_dyn_f;
   logic        m_start_black;
   logic [6:0]  m_width, m_height;
   phase_type   m_phase;
   int unsigned m_zeros;
   logic [31:0] m_accum;
   logic        m_in_repeat, m_black, m_done;
   logic [63:0] m_row;
   int unsigned m_left, m_rows, m_repeats;

   row_type     pending_rows[$];
   int          errors = 0;
   int          cycles = 0;
   int          rows_seen = 0;
   int          words_sent = 0;

   function automatic int unsigned width_now();
      return eff_dim(m_width, 7'(MAX_WIDTH));
   endfunction

   function automatic int unsigned height_now();
      return eff_dim(m_height, 7'(MAX_HEIGHT));
   endfunction

   function automatic void glyph_restart();
      m_phase = PH_FIRST;
      m_zeros = 0;
      m_accum = '0;
      m_in_repeat = 1'b0;
      m_black = m_start_black;
      m_row = '0;
      m_left = width_now();
      m_rows = 0;
      m_repeats = 0;
      m_done = 1'b0;
   endfunction

   function automatic void push_row();
      row_type r;
      if (m_done) return;
      r.bits = m_row;
      r.num = 6'(m_rows);
      r.last = (m_rows + 1 == height_now());
      pending_rows.push_back(r);
      m_rows++;
      if (m_rows >= height_now()) m_done = 1'b1;
   endfunction

   function automatic void close_row();
      int unsigned reps;
      reps = m_repeats;
      push_row();
      while (reps > 0 && !m_done) begin
         push_row();
         reps--;
      end
      m_repeats = 0;
      m_row = '0;
      m_left = width_now();
   endfunction

   function automatic void paint(longint unsigned count);
      int unsigned w, k, c;
      logic [63:0] ones;
      w = width_now();
      while (count > 0 && !m_done) begin
         k = (count < m_left) ? int'(count) : m_left;
         c = w - m_left;
         if (m_black) begin
            ones = (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
            m_row |= ones << (64 - c - k);
         end
         m_left -= k;
         count -= k;
         if (m_left == 0) close_row();
      end
      m_black = ~m_black;
   endfunction

   function automatic void use_number(longint v);
      if (v < 0) v = 0;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      if (m_in_repeat) begin
         m_repeats = (v > 127) ? 127 : int'(v);
         m_in_repeat = 1'b0;
      end else begin
         paint(longint'(v));
      end
   endfunction

   function automatic void decode_nybble(logic [3:0] n);
      longint d;
      d = longint'(m_dyn_f);
      case (m_phase)
         PH_ZEROS: begin
            if (n == 0) begin
               if (m_zeros < 15) m_zeros++;
            end else begin
               m_accum = 32'(n);
               m_phase = PH_LONG;
            end
         end
         PH_LONG: begin
            if (m_accum > 32'h0FFF_FFFF) m_accum = '1;
            else m_accum = {m_accum[27:0], n};
            if (m_zeros > 0) m_zeros--;
            if (m_zeros == 0) begin
               m_phase = PH_FIRST;
               use_number(longint'(m_accum) - 15 + (13 - d) * 16 + d);
            end
         end
         PH_SECOND: begin
            m_phase = PH_FIRST;
            use_number((longint'(m_accum) - d - 1) * 16 + longint'(n) + d + 1);
         end
         default: begin
            m_phase = PH_FIRST;
            if (n == 0) begin
               m_zeros = 1;
               m_phase = PH_ZEROS;
            end else if (n <= m_dyn_f) begin
               use_number(longint'(n));
            end else if (n < REPEAT_CODE) begin
               m_accum = 32'(n);
               m_phase = PH_SECOND;
            end else if (!m_in_repeat) begin
               if (n == REPEAT_CODE) m_in_repeat = 1'b1;
               else m_repeats = 1;
            end
         end
      endcase
   endfunction

   // expected rows for one accepted raster byte
   function automatic void predict_rows(logic start, logic [7:0] b);
      int unsigned w, c;
      w = width_now();
      if (start) glyph_restart();
      if (m_left == 0 || m_left > w) m_left = w;
      if (m_rows >= height_now()) m_done = 1'b1;
      if (m_done) return;
      if (m_dyn_f >= RAW_DYN_F) begin
         for (int i = 7; i >= 0 && !m_done; i--) begin
            c = w - m_left;
            if (b[i]) m_row[63 - c] = 1'b1;
            m_left--;
            if (m_left == 0) close_row();
         end
      end else begin
         decode_nybble(b[7:4]);
         if (!m_done) decode_nybble(b[3:0]);
      end
   endfunction

   function automatic void ref_defaults();
      m_dyn_f = RAW_DYN_F;
      m_start_black = 1'b0;
      m_width = 7'd64;
      m_height = 7'd64;
      glyph_restart();
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_DYN_F:        m_dyn_f = value[3:0];
         REG_START_BLACK:  m_start_black = value[0];
         REG_GLYPH_WIDTH:  m_width = value[6:0];
         default:          m_height = value[6:0];
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_glyph(int df, int sb, int w, int h);
      csr_write(REG_DYN_F, 32'(df));
      csr_write(REG_START_BLACK, 32'(sb));
      csr_write(REG_GLYPH_WIDTH, 32'(w));
      csr_write(REG_GLYPH_HEIGHT, 32'(h));
   endtask

   // block must be idle before a register write: rows drained, then margin
   task automatic drain();
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one raster word; valid stays high across back-to-back words
   task automatic send_byte(logic start, logic [7:0] b, bit gap_after);
      req_tvalid <= 1'b1;
      req_tuser <= start;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_rows(start, b);
      words_sent++;
      if (gap_after) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // sender bursts with random gaps
   int burst_left = 0;
   task automatic send_random_gap(logic start, logic [7:0] b);
      bit gap;
      if (burst_left == 0) burst_left = $urandom_range(1, 12);
      burst_left--;
      gap = (burst_left == 0) && ($urandom_range(0, 2) != 0);
      send_byte(start, b, gap);
   endtask

   // receiver: stall pattern alternating busy and free stretches
   int stall_mode = 0;
   int stall_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_count == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(4, 30);
         end else begin
            stall_count <= stall_count - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ((cycles % 5) < 2);
         endcase
      end
   end

   // row checker
   always @(posedge clock) begin
      row_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rows_seen++;
         if (pending_rows.size() == 0) begin
            $error("unexpected row word: bits %h", rsp_tdata[63:0]);
            errors++;
         end else begin
            e = pending_rows.pop_front();
            if (rsp_tdata[63:0] !== e.bits) begin
               $error("row_bits: expected %h, got %h", e.bits, rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[69:64] !== e.num) begin
               $error("row_number: expected %0d, got %0d", e.num, rsp_tdata[69:64]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_row: expected %0b, got %0b", e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d rows pending", cycles, pending_rows.size());
         $display("tb failed");
         $finish;
      end
   end

   // directed table: start flag, byte, and the row it must produce where obvious
   typedef struct {
      logic        start;
      logic [7:0]  b;
      logic        typed;
      logic [63:0] exp_bits;
      logic [5:0]  exp_num;
      logic        exp_last;
   } stim_type;

   stim_type bits_tab[3] = '{
      '{1'b1, 8'hFF, 1'b1, 64'hFF00_0000_0000_0000, 6'd0, 1'b0},
      '{1'b0, 8'h00, 1'b1, 64'h0000_0000_0000_0000, 6'd1, 1'b0},
      '{1'b0, 8'hA5, 1'b1, 64'hA500_0000_0000_0000, 6'd2, 1'b1}
   };

   initial begin
      row_type r;
      logic [7:0] b;
      int df, w, h;
      ref_defaults();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: raw mode, 64x64, white first; 16 bytes give 2 rows
      for (int i = 0; i < 16; i++) send_random_gap(i == 0, 8'(i * 37));
      req_tvalid <= 1'b0;
      drain();

      // directed raw: width 8 makes each byte a row; typed rows checked
      set_glyph(RAW_DYN_F, 0, 8, 3);
      foreach (bits_tab[i]) begin
         send_byte(bits_tab[i].start, bits_tab[i].b, 1'b0);
         if (bits_tab[i].typed) begin
            if (pending_rows.size() == 0) begin
               $error("row_bits: expected %h, got no row", bits_tab[i].exp_bits);
               errors++;
            end else begin
               r = pending_rows[$];
               if (r.bits !== bits_tab[i].exp_bits) begin
                  $error("row_bits: expected %h, got %h", bits_tab[i].exp_bits, r.bits);
                  errors++;
               end
               if (r.num !== bits_tab[i].exp_num) begin
                  $error("row_number: expected %0d, got %0d", bits_tab[i].exp_num, r.num);
                  errors++;
               end
               if (r.last !== bits_tab[i].exp_last) begin
                  $error("last_row: expected %0b, got %0b", bits_tab[i].exp_last, r.last);
                  errors++;
               end
            end
         end
      end
      req_tvalid <= 1'b0;
      drain();

      // raw with width above max and zero height; dyn_f 15 also raw
      set_glyph(15, 1, 100, 0);
      for (int i = 0; i < 9; i++) send_byte(i == 0, (i % 2) ? 8'h00 : 8'hFF, 1'b0);
      req_tvalid <= 1'b0;
      drain();

      // packed directed: short, two-nybble, long, saturating long, repeat codes
      set_glyph(0, 1, 1, 64);
      send_byte(1'b1, 8'h12, 1'b0);  // a two-nybble number with dyn_f 0
      send_byte(1'b0, 8'hE3, 1'b0);  // repeat count in two-nybble form
      send_byte(1'b0, 8'hFE, 1'b0);  // 15 ends the repeat count, then repeat code
      send_byte(1'b0, 8'hF1, 1'b0);  // 15 while decoding repeat: ignored
      send_byte(1'b0, 8'h13, 1'b1);
      req_tvalid <= 1'b0;
      drain();
      set_glyph(13, 0, 64, 64);
      send_byte(1'b1, 8'hD1, 1'b0);  // short values incl. dyn_f itself
      send_byte(1'b0, 8'h00, 1'b0);  // long form: many zeros
      send_byte(1'b0, 8'h00, 1'b0);
      send_byte(1'b0, 8'h00, 1'b0);
      send_byte(1'b0, 8'h00, 1'b0);
      send_byte(1'b0, 8'h00, 1'b0);
      send_byte(1'b0, 8'h00, 1'b0);
      send_byte(1'b0, 8'h00, 1'b0);
      send_byte(1'b0, 8'h00, 1'b0);
      for (int i = 0; i < 9; i++) send_byte(1'b0, 8'hFF, 1'b0);  // saturated run clips
      send_byte(1'b0, 8'h77, 1'b0);  // ignored after glyph end
      req_tvalid <= 1'b0;
      drain();

      // random glyphs over varied settings, extremes included
      for (int g = 0; g < 23; g++) begin
         case (g % 6)
            0: begin df = RAW_DYN_F; w = $urandom_range(1, 64); h = $urandom_range(1, 8); end
            1: begin df = 0; w = $urandom_range(1, 16); h = $urandom_range(1, 12); end
            2: begin df = 13; w = 64; h = 64; end
            3: begin df = $urandom_range(0, 15); w = $urandom_range(0, 127); h = $urandom_range(0, 10); end
            default: begin df = $urandom_range(1, 12); w = $urandom_range(1, 40); h = $urandom_range(1, 20); end
         endcase
         set_glyph(df, $urandom_range(0, 1), w, h);
         for (int i = 0; i < 9; i++) begin
            b = 8'($urandom);
            // mostly short runs so rows fill gradually; long-form leaders now and then
            if (df < RAW_DYN_F && $urandom_range(0, 9) < 7)
               b = {4'($urandom_range(1, 13)), 4'($urandom_range(1, 15))};
            send_random_gap((i == 0) || ($urandom_range(0, 40) == 0), b);
         end
         req_tvalid <= 1'b0;
         if (g == 10) begin
            // hold the sender until every row has come out
            while (pending_rows.size() != 0) @(posedge clock);
         end
         drain();
      end

      $display("sent %0d raster words over many register settings; %0d rows checked",
               words_sent, rows_seen);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/pfgr_pkg.sv
src/pfgr_ctrl.sv
src/pfgr_dp.sv
src/packed_font_glyph_raster_decoder_unit.sv
tb/tb.sv
